FILE: hdl/flvpt_pkg.sv
package flvpt_pkg;

    // Buffer geometry.
    localparam int MAX_CAND  = 8;
    localparam int MAX_LAG   = 8;
    localparam int SLOTS     = MAX_LAG + 1;
    localparam int CAND_W    = (MAX_CAND > 1) ? $clog2(MAX_CAND) : 1;
    localparam int CNT_W     = $clog2(MAX_CAND + 1);
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int K_W       = $clog2(SLOTS + 1);
    localparam int MEM_DEPTH = SLOTS * MAX_CAND;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    // Field widths.
    localparam int FREQ_W  = 20;
    localparam int EMIS_W  = 18;
    localparam int LOG_W   = 21;
    localparam int SCORE_W = 24;
    localparam int IDX_W   = 32;
    localparam int CONF_W  = 15;
    localparam int LAG_W   = 4;
    localparam int WIDTH_W = 13;
    localparam int CFG_IDX_W = 1;

    // Q14 constants of the transition model, with the jump threshold and octave in cents.
    localparam int PEN_RAMP   = 2949;
    localparam int PEN_JUMP   = 1966;
    localparam int JUMP_CENTS = 850;
    localparam int PEN_INVAL  = 16384;
    localparam int CONF_ONE   = 16384;
    localparam int CENTS_OCT  = 1200;

    // Commands.
    localparam logic [1:0] CMD_CAND   = 2'd0;
    localparam logic [1:0] CMD_SILENT = 2'd1;
    localparam logic [1:0] CMD_DRAIN  = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LAG   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 1'd1;

    // One stored candidate: frequency, score and its precomputed log2.
    typedef struct packed {
        logic [FREQ_W-1:0]        freq;
        logic signed [EMIS_W-1:0] score;
        logic [LOG_W-1:0]         log2;
    } cand_t;

    // Ring slot that lies ofs frames after base.
    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
                                                   input logic [K_W-1:0] ofs);
        logic [K_W:0] sum;
        sum = (K_W+1)'(base) + (K_W+1)'(ofs);
        if (sum >= (K_W+1)'(SLOTS)) begin
            sum = sum - (K_W+1)'(SLOTS);
        end
        return SLOT_W'(sum);
    endfunction

    // Memory address of candidate idx in a slot (or of a trellis column).
    function automatic logic [ADDR_W-1:0] mem_addr(input logic [SLOT_W-1:0] s,
                                                   input logic [CAND_W-1:0] i);
        return ADDR_W'(s) * ADDR_W'(MAX_CAND) + ADDR_W'(i);
    endfunction

    // Saturate to the signed path score range.
    function automatic logic signed [SCORE_W-1:0] sat24(input logic signed [SCORE_W+1:0] v);
        logic signed [SCORE_W+1:0] hi;
        logic signed [SCORE_W+1:0] lo;
        hi = (SCORE_W+2)'(signed'({1'b0, {(SCORE_W-1){1'b1}}}));
        lo = -hi - (SCORE_W+2)'(1);
        if (v > hi) begin
            return {1'b0, {(SCORE_W-1){1'b1}}};
        end else if (v < lo) begin
            return {1'b1, {(SCORE_W-1){1'b0}}};
        end
        return SCORE_W'(v);
    endfunction

endpackage

FILE: hdl/fixed_lag_viterbi_pitch_tracker.sv
// Fixed-lag Viterbi pitch tracker. Requests carry a command: a pitch candidate, a silent
// frame, a drain of one frame or a clear. A candidate request runs through the 16 squaring
// steps of the log2 unit; the log2 is stored with the candidate. When a frame completes and
// more frames are held than the lag register allows, or on a drain, the oldest frame is
// resolved by a Viterbi search over the voiced run that starts there. Each transition is
// one candidate memory read, cents, and a one bit per cycle penalty divider; the divider
// is skipped when either frequency is zero. Results wait in an output register while the
// next request is taken.
module fixed_lag_viterbi_pitch_tracker (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [flvpt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [flvpt_pkg::WIDTH_W-1:0]          cfg_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [1:0]                             s_command,
    input  logic [flvpt_pkg::FREQ_W-1:0]           s_frequency,
    input  logic signed [flvpt_pkg::EMIS_W-1:0]    s_emission_score,
    input  logic                                   s_last_in_frame,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [flvpt_pkg::IDX_W-1:0]            m_frame_index,
    output logic                                   m_voiced,
    output logic [flvpt_pkg::FREQ_W-1:0]           m_chosen_frequency,
    output logic [flvpt_pkg::CONF_W-1:0]           m_confidence,
    output logic signed [flvpt_pkg::SCORE_W-1:0]   m_path_score
);
    import flvpt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_NORM, S_LOG, S_WR, S_PUSH,
        R_START, R_LOAD0, R_LOAD1, R_FRAME,
        T_RD, T_CENT, T_RAMP, T_DIV, T_ACC, T_CUR,
        R_MAX0, R_MAX1, R_TB0, R_TB1, R_CHO0, R_CHO1, S_EMIT
    } state_t;

    state_t state_reg;

    // Configuration.
    logic [LAG_W-1:0]   lag_reg;
    logic [WIDTH_W-1:0] width_reg;

    // Ring bookkeeping.
    logic [SLOT_W-1:0] head_reg;
    logic [K_W-1:0]    held_reg;
    logic [CNT_W-1:0]  asm_reg;
    logic [IDX_W-1:0]  oldest_reg;
    logic [CNT_W-1:0]  sizes_reg [SLOTS];

    // Latched request.
    logic [FREQ_W-1:0]        freq_reg;
    logic signed [EMIS_W-1:0] score_reg;
    logic                     last_reg;

    // Log2 unit.
    logic [30:0] sqm_reg;
    logic [15:0] frac_reg;
    logic [3:0]  iter_reg;
    logic [4:0]  lp_reg;

    // Trellis walk.
    logic [K_W-1:0]    k_reg;
    logic [SLOT_W-1:0] ps_reg;
    logic [SLOT_W-1:0] cs_reg;
    logic [CNT_W-1:0]  np_reg;
    logic [CNT_W-1:0]  nc_reg;
    logic [CAND_W-1:0] p_reg;
    logic [CAND_W-1:0] c_reg;
    logic signed [SCORE_W-1:0] prev_reg [MAX_CAND];
    logic signed [SCORE_W-1:0] cur_reg  [MAX_CAND];
    logic [14:0]  cents_reg;
    logic         big_reg;
    logic [24:0]  rem_reg;
    logic [11:0]  q_reg;
    logic [3:0]   bit_reg;
    logic [14:0]  pen_reg;
    logic signed [EMIS_W-1:0]  sc_reg;
    logic signed [SCORE_W-1:0] b_reg;
    logic [CAND_W-1:0]         bi_reg;
    logic signed [SCORE_W-1:0] best_reg;
    logic [CAND_W-1:0]         sel_reg;

    // Pending result and output register.
    logic                      res_voiced_reg;
    logic [FREQ_W-1:0]         res_freq_reg;
    logic [CONF_W-1:0]         res_conf_reg;
    logic signed [SCORE_W-1:0] res_score_reg;
    logic                      m_valid_reg;
    logic [IDX_W-1:0]          m_index_reg;
    logic                      m_voiced_reg;
    logic [FREQ_W-1:0]         m_freq_reg;
    logic [CONF_W-1:0]         m_conf_reg;
    logic signed [SCORE_W-1:0] m_score_reg;

    // Memories.
    cand_t             cand_mem [MEM_DEPTH];
    cand_t             rda_reg;
    cand_t             rdb_reg;
    logic [CAND_W-1:0] back_mem [MEM_DEPTH];
    logic [CAND_W-1:0] back_rd_reg;

    logic              accept;
    logic [SLOT_W-1:0] tail;
    logic [SLOT_W-1:0] slot_k;
    logic [SLOT_W-1:0] sz_addr;
    logic [CNT_W-1:0]  sz_rd;
    logic [K_W-1:0]    lag_eff;
    logic [4:0]        lp_c;
    logic [30:0]       m_init;
    logic [61:0]       sq;
    logic [31:0]       sq_t;
    logic [LOG_W-1:0]  diff;
    logic [32:0]       cent_prod;
    logic [WIDTH_W-1:0] w_eff;
    logic [WIDTH_W-1:0] ramp;
    logic [24:0]       num;
    logic [24:0]       dsh;
    logic              ge;
    logic [11:0]       q_new;
    logic signed [SCORE_W-1:0] pv;
    logic signed [SCORE_W-1:0] s_val;
    logic signed [SCORE_W-1:0] cv;
    logic              cand_we;
    logic [ADDR_W-1:0] cand_waddr;
    logic [ADDR_W-1:0] ra;
    logic [ADDR_W-1:0] rb;
    logic              back_we;
    logic [ADDR_W-1:0] back_waddr;
    logic [ADDR_W-1:0] back_raddr;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);

    assign m_valid            = m_valid_reg;
    assign m_frame_index      = m_index_reg;
    assign m_voiced           = m_voiced_reg;
    assign m_chosen_frequency = m_freq_reg;
    assign m_confidence       = m_conf_reg;
    assign m_path_score       = m_score_reg;

    // Ring positions and the single frame size read port.
    assign tail    = slot_add(head_reg, held_reg);
    assign slot_k  = slot_add(head_reg, k_reg);
    assign sz_addr = (state_reg == R_START) ? head_reg : slot_k;
    assign sz_rd   = sizes_reg[sz_addr];
    assign lag_eff = (32'(lag_reg) > MAX_LAG) ? K_W'(MAX_LAG) : K_W'(lag_reg);

    // Log2 normalization: position of the leading one, mantissa in [2^30, 2^31).
    always_comb begin
        lp_c = 5'd0;
        for (int i = 1; i < FREQ_W; i++) begin
            if (freq_reg[i]) begin
                lp_c = 5'(i);
            end
        end
    end
    assign m_init = 31'({31'd0, freq_reg} << (5'd30 - lp_c));
    assign sq     = 62'(sqm_reg) * 62'(sqm_reg);
    assign sq_t   = sq[61:30];

    // Cents between the two candidates and the ramp numerator.
    assign diff = (rdb_reg.log2 > rda_reg.log2) ? (rdb_reg.log2 - rda_reg.log2)
                                                : (rda_reg.log2 - rdb_reg.log2);
    assign cent_prod = 33'(diff) * 33'(CENTS_OCT) + 33'(32768);
    assign w_eff = (width_reg == '0) ? WIDTH_W'(1) : width_reg;
    assign ramp  = (cents_reg < 15'(w_eff)) ? WIDTH_W'(cents_reg) : w_eff;
    assign num   = 25'(ramp) * 25'(PEN_RAMP) + 25'(w_eff >> 1);

    // Restoring divider step.
    assign dsh   = 25'(w_eff) << bit_reg;
    assign ge    = (rem_reg >= dsh);
    assign q_new = ge ? (q_reg | (12'd1 << bit_reg)) : q_reg;

    // Path score arithmetic.
    assign pv    = prev_reg[p_reg];
    assign s_val = sat24((SCORE_W+2)'(pv) - signed'({11'd0, pen_reg}));
    assign cv    = sat24((SCORE_W+2)'(b_reg) + (SCORE_W+2)'(sc_reg));

    // Memory addresses.
    assign cand_we    = (state_reg == S_WR);
    assign cand_waddr = mem_addr(tail, CAND_W'(asm_reg));
    assign rb         = mem_addr(cs_reg, c_reg);
    assign back_we    = (state_reg == T_CUR);
    assign back_waddr = mem_addr(SLOT_W'(k_reg), c_reg);
    assign back_raddr = mem_addr(SLOT_W'(k_reg - K_W'(1)), sel_reg);

    always_comb begin
        case (state_reg)
            T_RD:    ra = mem_addr(ps_reg, p_reg);
            R_CHO0:  ra = mem_addr(head_reg, sel_reg);
            default: ra = mem_addr(head_reg, c_reg);
        endcase
    end

    // Candidate store: one write port, two registered read ports.
    always_ff @(posedge aclk) begin
        if (cand_we) begin
            cand_mem[cand_waddr] <= '{freq: freq_reg, score: score_reg,
                                      log2: {lp_reg, frac_reg}};
        end
        rda_reg <= cand_mem[ra];
        rdb_reg <= cand_mem[rb];
    end

    // Back pointer store, one column per trellis step.
    always_ff @(posedge aclk) begin
        if (back_we) begin
            back_mem[back_waddr] <= bi_reg;
        end
        back_rd_reg <= back_mem[back_raddr];
    end

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            lag_reg     <= LAG_W'(5);
            width_reg   <= WIDTH_W'(100);
            head_reg    <= '0;
            held_reg    <= '0;
            asm_reg     <= '0;
            oldest_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_LAG:   lag_reg   <= LAG_W'(cfg_data);
                    REG_WIDTH: width_reg <= cfg_data;
                    default: ;
                endcase
            end
            // The emit state loads the output register itself.
            if (m_valid_reg && m_ready && state_reg != S_EMIT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        freq_reg  <= s_frequency;
                        score_reg <= s_emission_score;
                        last_reg  <= s_last_in_frame;
                        case (s_command)
                            CMD_CAND: begin
                                if (asm_reg < CNT_W'(MAX_CAND)) begin
                                    state_reg <= S_NORM;
                                end else if (s_last_in_frame) begin
                                    state_reg <= S_PUSH;
                                end
                            end
                            CMD_SILENT: begin
                                asm_reg   <= '0;
                                state_reg <= S_PUSH;
                            end
                            CMD_DRAIN: state_reg <= R_START;
                            default: begin
                                held_reg   <= '0;
                                head_reg   <= '0;
                                asm_reg    <= '0;
                                oldest_reg <= '0;
                            end
                        endcase
                    end
                end
                S_NORM: begin
                    lp_reg    <= lp_c;
                    sqm_reg   <= m_init;
                    frac_reg  <= '0;
                    iter_reg  <= '0;
                    state_reg <= S_LOG;
                end
                // One squaring step per cycle yields one fraction bit.
                S_LOG: begin
                    frac_reg <= {frac_reg[14:0], sq_t[31]};
                    sqm_reg  <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
                    iter_reg <= iter_reg + 4'd1;
                    if (iter_reg == 4'd15) begin
                        state_reg <= S_WR;
                    end
                end
                S_WR: begin
                    asm_reg   <= asm_reg + CNT_W'(1);
                    state_reg <= last_reg ? S_PUSH : S_IDLE;
                end
                S_PUSH: begin
                    sizes_reg[tail] <= asm_reg;
                    held_reg        <= held_reg + K_W'(1);
                    asm_reg         <= '0;
                    state_reg <= (held_reg + K_W'(1) > lag_eff) ? R_START : S_IDLE;
                end
                // Resolution of the oldest frame.
                R_START: begin
                    if (held_reg == '0) begin
                        state_reg <= S_IDLE;
                    end else if (sz_rd == '0) begin
                        res_voiced_reg <= 1'b0;
                        res_freq_reg   <= '0;
                        res_conf_reg   <= '0;
                        res_score_reg  <= '0;
                        state_reg      <= S_EMIT;
                    end else begin
                        nc_reg    <= sz_rd;
                        cs_reg    <= head_reg;
                        c_reg     <= '0;
                        state_reg <= R_LOAD0;
                    end
                end
                R_LOAD0: state_reg <= R_LOAD1;
                R_LOAD1: begin
                    prev_reg[c_reg] <= (SCORE_W)'(rda_reg.score);
                    if (CNT_W'(c_reg) == nc_reg - CNT_W'(1)) begin
                        k_reg     <= K_W'(1);
                        state_reg <= R_FRAME;
                    end else begin
                        c_reg     <= c_reg + CAND_W'(1);
                        state_reg <= R_LOAD0;
                    end
                end
                // Step to the next frame while the voiced run continues.
                R_FRAME: begin
                    if (k_reg < held_reg && sz_rd != '0) begin
                        ps_reg    <= cs_reg;
                        cs_reg    <= slot_k;
                        np_reg    <= nc_reg;
                        nc_reg    <= sz_rd;
                        c_reg     <= '0;
                        p_reg     <= '0;
                        state_reg <= T_RD;
                    end else begin
                        state_reg <= R_MAX0;
                    end
                end
                T_RD: state_reg <= T_CENT;
                T_CENT: begin
                    sc_reg    <= rdb_reg.score;
                    cents_reg <= cent_prod[30:16];
                    if (rda_reg.freq == '0 || rdb_reg.freq == '0) begin
                        pen_reg   <= 15'(PEN_INVAL);
                        state_reg <= T_ACC;
                    end else begin
                        state_reg <= T_RAMP;
                    end
                end
                T_RAMP: begin
                    rem_reg   <= num;
                    q_reg     <= '0;
                    bit_reg   <= 4'd11;
                    big_reg   <= (cents_reg >= 15'(JUMP_CENTS));
                    state_reg <= T_DIV;
                end
                T_DIV: begin
                    if (ge) begin
                        rem_reg <= rem_reg - dsh;
                    end
                    q_reg <= q_new;
                    if (bit_reg == 4'd0) begin
                        pen_reg   <= 15'(q_new) + (big_reg ? 15'(PEN_JUMP) : 15'd0);
                        state_reg <= T_ACC;
                    end else begin
                        bit_reg <= bit_reg - 4'd1;
                    end
                end
                // Best predecessor, ties to the lowest index.
                T_ACC: begin
                    if (p_reg == '0 || s_val > b_reg) begin
                        b_reg  <= s_val;
                        bi_reg <= p_reg;
                    end
                    if (CNT_W'(p_reg) == np_reg - CNT_W'(1)) begin
                        state_reg <= T_CUR;
                    end else begin
                        p_reg     <= p_reg + CAND_W'(1);
                        state_reg <= T_RD;
                    end
                end
                T_CUR: begin
                    cur_reg[c_reg] <= cv;
                    if (CNT_W'(c_reg) == nc_reg - CNT_W'(1)) begin
                        for (int i = 0; i < MAX_CAND; i++) begin
                            prev_reg[i] <= (CAND_W'(i) == c_reg) ? cv : cur_reg[i];
                        end
                        k_reg     <= k_reg + K_W'(1);
                        state_reg <= R_FRAME;
                    end else begin
                        c_reg     <= c_reg + CAND_W'(1);
                        p_reg     <= '0;
                        state_reg <= T_RD;
                    end
                end
                // Final maximum over the last frame of the run.
                R_MAX0: begin
                    best_reg <= prev_reg[0];
                    sel_reg  <= '0;
                    p_reg    <= CAND_W'(1);
                    state_reg <= (nc_reg == CNT_W'(1)) ? R_TB0 : R_MAX1;
                end
                R_MAX1: begin
                    if (pv > best_reg) begin
                        best_reg <= pv;
                        sel_reg  <= p_reg;
                    end
                    if (CNT_W'(p_reg) == nc_reg - CNT_W'(1)) begin
                        state_reg <= R_TB0;
                    end else begin
                        p_reg <= p_reg + CAND_W'(1);
                    end
                end
                // Traceback to the oldest frame.
                R_TB0: state_reg <= (k_reg == K_W'(1)) ? R_CHO0 : R_TB1;
                R_TB1: begin
                    sel_reg   <= back_rd_reg;
                    k_reg     <= k_reg - K_W'(1);
                    state_reg <= R_TB0;
                end
                R_CHO0: state_reg <= R_CHO1;
                R_CHO1: begin
                    res_voiced_reg <= 1'b1;
                    res_freq_reg   <= rda_reg.freq;
                    res_score_reg  <= best_reg;
                    if (rda_reg.score < 0) begin
                        res_conf_reg <= '0;
                    end else if (rda_reg.score > EMIS_W'(CONF_ONE)) begin
                        res_conf_reg <= CONF_W'(CONF_ONE);
                    end else begin
                        res_conf_reg <= CONF_W'(rda_reg.score);
                    end
                    state_reg <= S_EMIT;
                end
                // Hand the result to the output register and retire the frame.
                S_EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_index_reg  <= oldest_reg;
                        m_voiced_reg <= res_voiced_reg;
                        m_freq_reg   <= res_freq_reg;
                        m_conf_reg   <= res_conf_reg;
                        m_score_reg  <= res_score_reg;
                        head_reg     <= slot_add(head_reg, K_W'(1));
                        held_reg     <= held_reg - K_W'(1);
                        oldest_reg   <= oldest_reg + IDX_W'(1);
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_held_range: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= K_W'(SLOTS))
        else $error("frame count exceeds ring size");
    a_asm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        asm_reg <= CNT_W'(MAX_CAND))
        else $error("assembling count exceeds frame capacity");
    a_unvoiced_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_voiced |-> m_chosen_frequency == '0 && m_path_score == '0)
        else $error("unvoiced result carries a frequency or score");
    a_emit_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_EMIT && (!m_valid_reg || m_ready) |=> m_valid_reg)
        else $error("resolved frame did not reach the output register");
`endif

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import flvpt_pkg::*;

    localparam longint CYCLE_LIMIT = 60_000_000;
    localparam int LONG_HOLD = 30000;

    // One resolved frame as it leaves the tracker.
    typedef struct {
        logic [IDX_W-1:0]          frame_index;
        logic                      voiced;
        logic [FREQ_W-1:0]         freq;
        logic [CONF_W-1:0]         conf;
        logic signed [SCORE_W-1:0] score;
    } pitch_result_t;

    // Tracks the frame ring alongside the block and holds the pitch decisions still due.
    class pitch_scoreboard;
        int unsigned cand_freq[SLOTS][MAX_CAND];
        int cand_score[SLOTS][MAX_CAND];
        int unsigned slot_size[SLOTS];
        int unsigned ring_head, frames_held, assembling;
        logic [IDX_W-1:0] oldest_idx, next_idx;
        int unsigned lag, width;
        pitch_result_t pending[$];
        int errors;

        function new();
            ring_head = 0;
            frames_held = 0;
            assembling = 0;
            oldest_idx = 0;
            next_idx = 0;
            lag = 5;
            width = 100;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
            if (idx == REG_LAG) begin
                lag = value & 4'hf;
            end else if (idx == REG_WIDTH) begin
                width = value & 13'h1fff;
            end
        endfunction

        static function int clip_score(longint v);
            if (v > 8388607) begin
                return 8388607;
            end else if (v < -8388608) begin
                return -8388608;
            end
            return int'(v);
        endfunction

        // Base-2 logarithm with 16 fraction bits, by repeated squaring of the mantissa.
        static function int unsigned pitch_log2(int unsigned f);
            int unsigned p;
            int unsigned frac;
            longint unsigned m;
            p = 0;
            frac = 0;
            while (p < 19 && (f >> (p + 1)) != 0) begin
                p++;
            end
            m = longint'(f) << (30 - p);
            for (int i = 0; i < 16; i++) begin
                m = (m * m) >> 30;
                frac = frac << 1;
                if (m >= (64'd1 << 31)) begin
                    frac |= 1;
                    m = m >> 1;
                end
            end
            return (p << 16) | frac;
        endfunction

        // Score of a pitch move; invalid frequencies cost a full unit.
        function int jump_score(int unsigned from_f, int unsigned to_f);
            int unsigned lf, lt, diff, cents, w, ramp, pen;
            if (from_f == 0 || to_f == 0) begin
                return -PEN_INVAL;
            end
            lf = pitch_log2(from_f);
            lt = pitch_log2(to_f);
            diff = (lt > lf) ? lt - lf : lf - lt;
            cents = int'((longint'(diff) * CENTS_OCT + 32768) >> 16);
            w = (width < 1) ? 1 : width;
            ramp = (cents < w) ? cents : w;
            pen = (PEN_RAMP * ramp + w / 2) / w;
            if (cents >= JUMP_CENTS) begin
                pen += PEN_JUMP;
            end
            return -int'(pen);
        endfunction

        // Viterbi over the voiced run at the oldest frame; queues the decision if any.
        function void resolve_oldest();
            int prev[MAX_CAND];
            int cur[MAX_CAND];
            int unsigned back[SLOTS][MAX_CAND];
            int unsigned head, n0, voiced, ps, cs, np, nc, bi, sel, nl;
            int b, s, best;
            pitch_result_t r;
            if (frames_held == 0) begin
                return;
            end
            head = ring_head % SLOTS;
            n0 = slot_size[head];
            r.frame_index = oldest_idx;
            if (n0 == 0) begin
                r.voiced = 0;
                r.freq = 0;
                r.conf = 0;
                r.score = 0;
            end else begin
                voiced = 0;
                while (voiced < frames_held && slot_size[(head + voiced) % SLOTS] != 0) begin
                    voiced++;
                end
                for (int c = 0; c < n0; c++) begin
                    prev[c] = cand_score[head][c];
                end
                for (int k = 1; k < voiced; k++) begin
                    ps = (head + k - 1) % SLOTS;
                    cs = (head + k) % SLOTS;
                    np = slot_size[ps];
                    nc = slot_size[cs];
                    for (int c = 0; c < nc; c++) begin
                        b = 0;
                        bi = 0;
                        for (int p = 0; p < np; p++) begin
                            s = clip_score(longint'(prev[p]) +
                                jump_score(cand_freq[ps][p], cand_freq[cs][c]));
                            if (p == 0 || s > b) begin
                                b = s;
                                bi = p;
                            end
                        end
                        back[k][c] = bi;
                        cur[c] = clip_score(longint'(b) + cand_score[cs][c]);
                    end
                    for (int c = 0; c < nc; c++) begin
                        prev[c] = cur[c];
                    end
                end
                nl = slot_size[(head + voiced - 1) % SLOTS];
                sel = 0;
                best = prev[0];
                for (int c = 1; c < nl; c++) begin
                    if (prev[c] > best) begin
                        best = prev[c];
                        sel = c;
                    end
                end
                for (int k = voiced - 1; k > 0; k--) begin
                    sel = back[k][sel % MAX_CAND];
                end
                sel = sel % MAX_CAND;
                r.voiced = 1;
                r.freq = FREQ_W'(cand_freq[head][sel]);
                if (cand_score[head][sel] < 0) begin
                    r.conf = 0;
                end else if (cand_score[head][sel] > CONF_ONE) begin
                    r.conf = CONF_W'(CONF_ONE);
                end else begin
                    r.conf = CONF_W'(cand_score[head][sel]);
                end
                r.score = SCORE_W'(best);
            end
            pending = {pending, r};
            ring_head = (head + 1) % SLOTS;
            frames_held--;
            oldest_idx++;
        endfunction

        function void close_frame(int unsigned count);
            int unsigned eff_lag;
            eff_lag = (lag > MAX_LAG) ? MAX_LAG : lag;
            slot_size[(ring_head + frames_held) % SLOTS] = count;
            frames_held++;
            next_idx++;
            assembling = 0;
            if (frames_held > eff_lag) begin
                resolve_oldest();
            end
        endfunction

        // Called for every request the tracker accepts.
        function void note_request(logic [1:0] cmd, logic [FREQ_W-1:0] freq,
                                   logic signed [EMIS_W-1:0] score, logic last);
            int unsigned tail;
            case (cmd)
                CMD_CAND: begin
                    if (assembling < MAX_CAND) begin
                        tail = (ring_head + frames_held) % SLOTS;
                        cand_freq[tail][assembling] = freq;
                        cand_score[tail][assembling] = score;
                        assembling++;
                    end
                    if (last) begin
                        close_frame(assembling);
                    end
                end
                CMD_SILENT: close_frame(0);
                CMD_DRAIN: resolve_oldest();
                default: begin
                    frames_held = 0;
                    ring_head = 0;
                    assembling = 0;
                    oldest_idx = 0;
                    next_idx = 0;
                end
            endcase
        endfunction

        function void check_result(pitch_result_t got);
            pitch_result_t exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result for frame %0d", $time, got.frame_index);
                errors++;
                return;
            end
            exp_r = pending[0];
            pending.delete(0);
            if (got.frame_index !== exp_r.frame_index) begin
                $display("%0t: frame_index expected %0d got %0d", $time,
                         exp_r.frame_index, got.frame_index);
                errors++;
            end
            if (got.voiced !== exp_r.voiced) begin
                $display("%0t: voiced expected %0d got %0d", $time, exp_r.voiced, got.voiced);
                errors++;
            end
            if (got.freq !== exp_r.freq) begin
                $display("%0t: chosen_frequency expected %0d got %0d", $time,
                         exp_r.freq, got.freq);
                errors++;
            end
            if (got.conf !== exp_r.conf) begin
                $display("%0t: confidence expected %0d got %0d", $time, exp_r.conf, got.conf);
                errors++;
            end
            if (got.score !== exp_r.score) begin
                $display("%0t: whole path score expected %0d got %0d", $time,
                         exp_r.score, got.score);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WIDTH_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_command = CMD_CAND;
    logic [FREQ_W-1:0] s_frequency = '0;
    logic signed [EMIS_W-1:0] s_emission_score = '0;
    logic s_last_in_frame = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [IDX_W-1:0] m_frame_index;
    logic m_voiced;
    logic [FREQ_W-1:0] m_chosen_frequency;
    logic [CONF_W-1:0] m_confidence;
    logic signed [SCORE_W-1:0] m_path_score;

    pitch_scoreboard sb = new();
    longint cycles = 0;
    bit hold_request = 0;
    int sent = 0;

    fixed_lag_viterbi_pitch_tracker dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_frequency(s_frequency), .s_emission_score(s_emission_score),
        .s_last_in_frame(s_last_in_frame),
        .m_valid(m_valid), .m_ready(m_ready), .m_frame_index(m_frame_index),
        .m_voiced(m_voiced), .m_chosen_frequency(m_chosen_frequency),
        .m_confidence(m_confidence), .m_path_score(m_path_score)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run limit.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("fixed_lag_viterbi_pitch_tracker: mismatch");
            $finish;
        end
    end

    // Result side: check every accepted result.
    always @(posedge aclk) begin
        pitch_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.frame_index = m_frame_index;
            got.voiced = m_voiced;
            got.freq = m_chosen_frequency;
            got.conf = m_confidence;
            got.score = m_path_score;
            sb.check_result(got);
        end
    end

    // Result side back-pressure: random stalls and one long hold-off on request.
    initial begin
        int stall;
        int pick;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_ready = 1'b0;
                for (int i = 0; i < LONG_HOLD; i++) begin
                    @(negedge aclk);
                end
                hold_request = 0;
                m_ready = 1'b1;
            end else if (stall > 0) begin
                stall--;
                m_ready = (stall == 0);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    m_ready = 1'b1;
                end else begin
                    stall = (pick < 96) ? $urandom_range(1, 4) : $urandom_range(20, 300);
                    m_ready = 1'b0;
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = WIDTH_W'(value);
        sb.set_reg(idx, value);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // Offer one request and hold it until taken, then idle for a random gap.
    task automatic send_request(logic [1:0] cmd, logic [FREQ_W-1:0] freq,
                                logic signed [EMIS_W-1:0] score, logic last);
        int pick;
        int gap;
        @(negedge aclk);
        s_valid = 1'b1;
        s_command = cmd;
        s_frequency = freq;
        s_emission_score = score;
        s_last_in_frame = last;
        do begin
            @(posedge aclk);
        end while (!(s_valid && s_ready));
        sb.note_request(cmd, freq, score, last);
        sent++;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            gap = 0;
        end else if (pick < 95) begin
            gap = $urandom_range(1, 4);
        end else begin
            gap = $urandom_range(20, 120);
        end
        if (gap > 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // Stop offering, wait for every pending decision, then let in-flight requests finish.
    task automatic settle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.pending.size() != 0) begin
            @(posedge aclk);
        end
        repeat (200) @(posedge aclk);
    endtask

    function automatic logic [FREQ_W-1:0] pick_freq(int unsigned base);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            return '0;
        end else if (pick < 12) begin
            return FREQ_W'($urandom_range(0, 20'hfffff));
        end
        return FREQ_W'(base + $urandom_range(0, base) - base / 3);
    endfunction

    function automatic logic signed [EMIS_W-1:0] pick_score();
        if ($urandom_range(0, 9) == 0) begin
            return EMIS_W'($urandom_range(0, 18'h3ffff));
        end
        return EMIS_W'($urandom_range(0, 20000) - 2000);
    endfunction

    // One well-formed frame of random size and content.
    task automatic send_frame();
        int pick;
        int n;
        int unsigned base;
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
            n = $urandom_range(1, 3);
        end else if (pick < 97) begin
            n = $urandom_range(4, 8);
        end else begin
            n = $urandom_range(9, 10);
        end
        base = $urandom_range(1600, 16000);
        for (int i = 0; i < n; i++) begin
            send_request(CMD_CAND, pick_freq(base), pick_score(), i == n - 1);
        end
    endtask

    // Mostly whole frames, with silent frames, drains, clears and broken frames mixed in.
    task automatic random_phase(int count);
        int goal;
        int pick;
        goal = sent + count;
        while (sent < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 78) begin
                send_frame();
            end else if (pick < 87) begin
                send_request(CMD_SILENT, FREQ_W'($urandom), EMIS_W'($urandom), 1'($urandom));
            end else if (pick < 94) begin
                send_request(CMD_DRAIN, FREQ_W'($urandom), EMIS_W'($urandom), 1'($urandom));
            end else if (pick < 98) begin
                repeat ($urandom_range(1, 3)) begin
                    send_request(CMD_CAND, pick_freq(4000), pick_score(), 1'b0);
                end
                send_request(($urandom_range(0, 1) != 0) ? CMD_SILENT : CMD_DRAIN,
                             FREQ_W'($urandom), EMIS_W'($urandom), 1'($urandom));
            end else begin
                send_request(CMD_CLEAR, FREQ_W'($urandom), EMIS_W'($urandom), 1'($urandom));
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: drain with nothing held, field extremes, an overfull frame,
        // silence during assembly, drain during assembly and a clear.
        send_request(CMD_DRAIN, 20'hfffff, 18'sh1ffff, 1'b1);
        send_request(CMD_CAND, 20'hfffff, 18'sh1ffff, 1'b1);
        send_request(CMD_CAND, 20'd0, -18'sd131072, 1'b0);
        send_request(CMD_CAND, 20'd1, 18'sd16384, 1'b1);
        for (int i = 0; i < 10; i++) begin
            send_request(CMD_CAND, 20'd3200 + 20'(i * 150), 18'(i * 3000 - 5000), i == 9);
        end
        send_request(CMD_CAND, 20'd7000, 18'sd9000, 1'b0);
        send_request(CMD_SILENT, 20'd0, 18'sd0, 1'b0);
        send_request(CMD_CAND, 20'd5000, 18'sd16385, 1'b0);
        send_request(CMD_DRAIN, 20'd0, 18'sd0, 1'b0);
        send_request(CMD_CAND, 20'd8500, 18'sd12000, 1'b1);
        send_request(CMD_CAND, 20'd2, -18'sd1, 1'b1);
        send_request(CMD_DRAIN, 20'd0, 18'sd0, 1'b0);
        send_request(CMD_CLEAR, 20'hfffff, -18'sd1, 1'b1);
        send_request(CMD_CAND, 20'd4000, 18'sd8000, 1'b1);
        settle();

        // Frames still held when the lag drops to zero resolve one per new frame.
        write_reg(REG_LAG, 0);
        write_reg(REG_WIDTH, 1);
        random_phase(340);
        settle();

        write_reg(REG_LAG, 8);
        write_reg(REG_WIDTH, 4800);
        hold_request = 1;
        random_phase(360);
        settle();

        write_reg(REG_LAG, 3);
        write_reg(REG_WIDTH, 850);
        random_phase(340);
        settle();

        write_reg(REG_LAG, 1);
        write_reg(REG_WIDTH, 37);
        random_phase(340);
        settle();

        write_reg(REG_LAG, 6);
        write_reg(REG_WIDTH, 300);
        random_phase(360);

        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.pending.size() != 0) begin
            @(posedge aclk);
        end
        repeat (500) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("fixed_lag_viterbi_pitch_tracker: match");
        end else begin
            $display("fixed_lag_viterbi_pitch_tracker: mismatch");
        end
        $finish;
    end

endmodule
